@@ rtl/core/tmtw_pkg.sv @@
// Shared types, character codes and command codes for the text-mode terminal writer.
// No dependencies; every other file of the block refers to this package by scoped names.
package tmtw_pkg;

    // Screen geometry defaults
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int INDEX_W = 11;
    localparam int ENTRY_W = CHAR_W + COLOR_W;

    // Colors
    localparam logic [COLOR_W-1:0] COLOR_RED        = 8'h04;
    localparam logic [COLOR_W-1:0] COLOR_LIGHT_GREY = 8'h07;

    // Tab expansion
    localparam int TAB_SPACES = 8;
    localparam int TAB_W      = $clog2(TAB_SPACES);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Command codes
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_PRINT = 3'd0;
    localparam logic [OP_W-1:0] OP_BELL  = 3'd1;
    localparam logic [OP_W-1:0] OP_BS    = 3'd2;
    localparam logic [OP_W-1:0] OP_TAB   = 3'd3;
    localparam logic [OP_W-1:0] OP_NL    = 3'd4;
    localparam logic [OP_W-1:0] OP_VT    = 3'd5;
    localparam logic [OP_W-1:0] OP_FF    = 3'd6;
    localparam logic [OP_W-1:0] OP_CR    = 3'd7;

    // Classified command
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } qhead_t;

endpackage

@@ rtl/core/tmtw_if.sv @@
// Channel interfaces of the text-mode terminal writer: character input and cell write output.
// Depends on tmtw_pkg for field widths.
interface tmtw_char_if;
    logic                         valid;
    logic                         ready;
    logic [tmtw_pkg::CHAR_W-1:0]  char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface tmtw_cell_if;
    logic                          valid;
    logic                          ready;
    logic [tmtw_pkg::INDEX_W-1:0]  cell_index;
    logic [tmtw_pkg::ENTRY_W-1:0]  cell_entry;
    logic                          last_write;

    modport source (output valid, output cell_index, output cell_entry, output last_write,
                    input ready);
    modport sink   (input valid, input cell_index, input cell_entry, input last_write,
                    output ready);
endinterface

@@ rtl/core/text_mode_terminal_writer_unit.sv @@
// Top level of the text-mode terminal writer: front end, command queue and back end.
// Depends on tmtw_pkg, tmtw_if, tmtw_front, tmtw_queue and tmtw_back.
//
//  Channel   Direction  Payload                                Handshake
//  chars     in         char_code[7:0]                         valid / ready
//  cells     out        cell_index[10:0], cell_entry[15:0],    valid / ready
//                       last_write
//
// The back end runs queued commands: a printable character gives one cell write,
// a backspace one unless the cursor is at the home cell, a cursor or color control
// code none. A tab gives eight cell writes, one per cycle while the output does not
// stall, limited by the single output register. A four-entry queue lets characters
// be accepted while the back end works or the output stalls; NUL is dropped at the input.
// Reset puts the cursor at row 0, column 0 and the color at light grey on black.
module text_mode_terminal_writer_unit #(
    parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
    input  logic         clk,
    input  logic         rst_n,
    tmtw_char_if.sink    chars,
    tmtw_cell_if.source  cells
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    tmtw_pkg::cmd_t    q_push_cmd;
    tmtw_pkg::qhead_t  q_head;

    // Classify incoming characters
    tmtw_front u_front (
        .chars    (chars),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    // Buffer commands between the two halves
    tmtw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .head     (q_head),
        .pop      (q_pop)
    );

    // Execute commands and drive cell writes
    tmtw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .pop      (q_pop),
        .cells    (cells)
    );

endmodule

@@ rtl/core/tmtw_front.sv @@
// Front end: accepts character transactions and classifies them into commands.
// Depends on tmtw_pkg and tmtw_char_if; feeds tmtw_queue.
module tmtw_front (
    tmtw_char_if.sink          chars,
    input  logic               q_full,
    output logic               push,
    output tmtw_pkg::cmd_t     push_cmd
);

    logic [tmtw_pkg::OP_W-1:0] op;
    logic                      is_nul;

    // Accept whenever the queue has room
    assign chars.ready = !q_full;

    // Classify the character code
    always_comb
    begin
        is_nul = 1'b0;
        case (chars.char_code)
            tmtw_pkg::CH_NUL:
            begin
                op     = tmtw_pkg::OP_PRINT;
                is_nul = 1'b1;
            end
            tmtw_pkg::CH_BEL: op = tmtw_pkg::OP_BELL;
            tmtw_pkg::CH_BS:  op = tmtw_pkg::OP_BS;
            tmtw_pkg::CH_TAB: op = tmtw_pkg::OP_TAB;
            tmtw_pkg::CH_LF:  op = tmtw_pkg::OP_NL;
            tmtw_pkg::CH_VT:  op = tmtw_pkg::OP_VT;
            tmtw_pkg::CH_FF:  op = tmtw_pkg::OP_FF;
            tmtw_pkg::CH_CR:  op = tmtw_pkg::OP_CR;
            default:          op = tmtw_pkg::OP_PRINT;
        endcase
    end

    // Drop NUL at the door; queue everything else
    assign push        = chars.valid && !q_full && !is_nul;
    assign push_cmd.op = op;
    assign push_cmd.ch = chars.char_code;

endmodule

@@ rtl/core/tmtw_queue.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on tmtw_pkg for the command type and depth.
module tmtw_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tmtw_pkg::cmd_t     push_cmd,
    output logic               full,
    output tmtw_pkg::qhead_t   head,
    input  logic               pop
);

    localparam int DEPTH = tmtw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tmtw_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/core/tmtw_back.sv @@
// Back end: executes queued commands against the cursor and color, and drives cell writes.
// Depends on tmtw_pkg, tmtw_cell_if and the queue head from tmtw_queue.
module tmtw_back #(
    parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tmtw_pkg::qhead_t   head,
    output logic               pop,
    tmtw_cell_if.source        cells
);

    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int INDEX_W = tmtw_pkg::INDEX_W;
    localparam int TAB_W   = tmtw_pkg::TAB_W;

    localparam logic [COL_W-1:0]   COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [INDEX_W-1:0] COLS_IDX  = INDEX_W'(COLUMNS);
    localparam logic [TAB_W-1:0]   TAB_FINAL = TAB_W'(tmtw_pkg::TAB_SPACES - 1);

    // Cursor, color and tab progress
    logic [ROW_W-1:0]                 row_reg, row_next;
    logic [COL_W-1:0]                 col_reg, col_next;
    logic [tmtw_pkg::COLOR_W-1:0]     color_reg, color_next;
    logic [TAB_W-1:0]                 tab_reg, tab_next;

    // Output register
    logic                             out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]               index_reg;
    logic [tmtw_pkg::ENTRY_W-1:0]     entry_reg;
    logic                             last_reg;

    logic                             can_emit;
    logic                             emit;
    logic                             emit_last;
    logic [ROW_W-1:0]                 emit_row;
    logic [COL_W-1:0]                 emit_col;
    logic [tmtw_pkg::CHAR_W-1:0]      emit_ch;
    logic [INDEX_W-1:0]               emit_index;
    logic [ROW_W-1:0]                 inc_row;
    logic [ROW_W-1:0]                 adv_row;
    logic [COL_W-1:0]                 adv_col;

    // Output slot is free or drains this cycle
    assign can_emit = !out_valid_reg || cells.ready;

    // Next row with wrap, and one-column advance with row wrap
    assign inc_row = (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
    assign adv_col = (col_reg == COL_LAST) ? '0 : col_reg + 1'b1;
    assign adv_row = (col_reg == COL_LAST) ? inc_row : row_reg;

    // Cell index of the write position, kept to the field width
    assign emit_index = INDEX_W'(INDEX_W'(emit_row) * COLS_IDX) + INDEX_W'(emit_col);

    // Execute the command at the head of the queue
    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        color_next = color_reg;
        tab_next   = tab_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_last  = 1'b1;
        emit_row   = row_reg;
        emit_col   = col_reg;
        emit_ch    = head.cmd.ch;
        if (head.valid)
        begin
            case (head.cmd.op)
                tmtw_pkg::OP_PRINT:
                begin
                    if (can_emit)
                    begin
                        emit     = 1'b1;
                        pop      = 1'b1;
                        row_next = adv_row;
                        col_next = adv_col;
                    end
                end
                tmtw_pkg::OP_BELL:
                begin
                    color_next = tmtw_pkg::COLOR_RED;
                    pop        = 1'b1;
                end
                tmtw_pkg::OP_BS:
                begin
                    emit_ch = tmtw_pkg::CH_SPACE;
                    if (col_reg != '0)
                    begin
                        emit_col = col_reg - 1'b1;
                        if (can_emit)
                        begin
                            emit     = 1'b1;
                            pop      = 1'b1;
                            col_next = emit_col;
                        end
                    end
                    else if (row_reg != '0)
                    begin
                        emit_row = row_reg - 1'b1;
                        emit_col = COL_LAST;
                        if (can_emit)
                        begin
                            emit     = 1'b1;
                            pop      = 1'b1;
                            row_next = emit_row;
                            col_next = emit_col;
                        end
                    end
                    else
                    begin
                        // home cell: nothing to erase
                        pop = 1'b1;
                    end
                end
                tmtw_pkg::OP_TAB:
                begin
                    emit_ch   = tmtw_pkg::CH_SPACE;
                    emit_last = (tab_reg == TAB_FINAL);
                    if (can_emit)
                    begin
                        emit     = 1'b1;
                        row_next = adv_row;
                        col_next = adv_col;
                        if (tab_reg == TAB_FINAL)
                        begin
                            tab_next = '0;
                            pop      = 1'b1;
                        end
                        else
                        begin
                            tab_next = tab_reg + 1'b1;
                        end
                    end
                end
                tmtw_pkg::OP_NL:
                begin
                    col_next = '0;
                    row_next = inc_row;
                    pop      = 1'b1;
                end
                tmtw_pkg::OP_VT:
                begin
                    row_next = inc_row;
                    col_next = (col_reg == COL_LAST) ? col_reg : col_reg + 1'b1;
                    pop      = 1'b1;
                end
                tmtw_pkg::OP_FF:
                begin
                    row_next = '0;
                    col_next = '0;
                    pop      = 1'b1;
                end
                tmtw_pkg::OP_CR:
                begin
                    col_next = '0;
                    pop      = 1'b1;
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    // Hold the output slot until taken, refill when free
    assign out_valid_next = can_emit ? emit : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            color_reg     <= tmtw_pkg::COLOR_LIGHT_GREY;
            tab_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            color_reg     <= color_next;
            tab_reg       <= tab_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the write payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            index_reg <= emit_index;
            entry_reg <= {color_reg, emit_ch};
            last_reg  <= emit_last;
        end
    end

    assign cells.valid      = out_valid_reg;
    assign cells.cell_index = index_reg;
    assign cells.cell_entry = entry_reg;
    assign cells.last_write = last_reg;

`ifndef SYNTH
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(col_reg) < COLUMNS)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(row_reg) < ROWS)
        else $error("cursor row out of range");

    a_tab_owner: assert property (@(posedge clk) disable iff (!rst_n)
        tab_reg != '0 |-> head.valid && head.cmd.op == tmtw_pkg::OP_TAB)
        else $error("tab progress without a tab at the queue head");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !cells.ready |-> !emit)
        else $error("cell write issued into a stalled output slot");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from an empty queue");
`endif

endmodule

@@ tb/cell_write_checker.sv @@
`timescale 1ns / 1ps
// Checker for the text-mode terminal writer: watches the character and cell channels,
// predicts the cell writes of each accepted character and compares them in order.
// Depends on tmtw_pkg and the channel interfaces in tmtw_if.
module cell_write_checker #(
    parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
    input  logic  clk,
    input  logic  rst_n,
    tmtw_char_if  chars,
    tmtw_cell_if  cells,
    output int    fail_count,
    output int    pending,
    output int    chars_seen,
    output int    cells_seen
);
    import tmtw_pkg::*;

    typedef struct {
        logic [INDEX_W-1:0] cell_index;
        logic [ENTRY_W-1:0] cell_entry;
        logic               last_write;
    } cell_write_t;

    // Terminal state as the block should hold it
    logic [4:0]         row_q;
    logic [6:0]         col_q;
    logic [COLOR_W-1:0] color_q;

    cell_write_t expected_writes[$];
    int          error_total;
    int          pending_total;
    int          char_total;
    int          cell_total;

    assign fail_count = error_total;
    assign pending    = pending_total;
    assign chars_seen = char_total;
    assign cells_seen = cell_total;

    initial
    begin
        row_q         = '0;
        col_q         = '0;
        color_q       = COLOR_LIGHT_GREY;
        error_total   = 0;
        pending_total = 0;
        char_total    = 0;
        cell_total    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_total++;
    endtask

    // Queue one cell write at the current cursor with the current color
    task automatic push_write(input logic [CHAR_W-1:0] code, input logic last);
        cell_write_t w;
        int          idx;
        idx          = int'(row_q) * COLUMNS + int'(col_q);
        w.cell_index = idx[INDEX_W-1:0];
        w.cell_entry = {color_q, code};
        w.last_write = last;
        expected_writes.push_back(w);
    endtask

    // Advance one column, wrapping to the next row and from the last row to the top
    task automatic advance_cursor();
        if (int'(col_q) + 1 >= COLUMNS)
        begin
            col_q = '0;
            row_q = (int'(row_q) + 1 >= ROWS) ? '0 : row_q + 5'd1;
        end
        else
            col_q = col_q + 7'd1;
    endtask

    // Work out the cell writes of one character and update the terminal state
    task automatic predict_cell_writes(input logic [CHAR_W-1:0] code);
        int i;
        case (code)
            CH_NUL: ;
            CH_BEL: color_q = COLOR_RED;
            CH_BS:
            begin
                if (col_q != '0)
                begin
                    col_q = col_q - 7'd1;
                    push_write(CH_SPACE, 1'b1);
                end
                else if (row_q != '0)
                begin
                    row_q = row_q - 5'd1;
                    col_q = 7'(COLUMNS - 1);
                    push_write(CH_SPACE, 1'b1);
                end
            end
            CH_TAB:
            begin
                for (i = 0; i < TAB_SPACES; i++)
                begin
                    push_write(CH_SPACE, i == TAB_SPACES - 1);
                    advance_cursor();
                end
            end
            CH_LF:
            begin
                col_q = '0;
                row_q = (int'(row_q) + 1 >= ROWS) ? '0 : row_q + 5'd1;
            end
            CH_VT:
            begin
                row_q = (int'(row_q) + 1 >= ROWS) ? '0 : row_q + 5'd1;
                // saturate at the last column
                if (int'(col_q) + 1 < COLUMNS)
                    col_q = col_q + 7'd1;
            end
            CH_FF:
            begin
                row_q = '0;
                col_q = '0;
            end
            CH_CR: col_q = '0;
            default:
            begin
                push_write(code, 1'b1);
                advance_cursor();
            end
        endcase
    endtask

    // Predict on each accepted character, compare each accepted cell write
    always @(posedge clk)
    begin
        cell_write_t w;
        if (rst_n)
        begin
            if (chars.valid && chars.ready)
            begin
                char_total++;
                predict_cell_writes(chars.char_code);
            end
            if (cells.valid && cells.ready)
            begin
                cell_total++;
                if (expected_writes.size() == 0)
                    report_mismatch($sformatf("unexpected cell write index=%0d entry=%h last=%b",
                                              cells.cell_index, cells.cell_entry,
                                              cells.last_write));
                else
                begin
                    w = expected_writes.pop_front();
                    if (cells.cell_index !== w.cell_index)
                        report_mismatch($sformatf("cell_index %0d, expected %0d",
                                                  cells.cell_index, w.cell_index));
                    if (cells.cell_entry !== w.cell_entry)
                        report_mismatch($sformatf("cell_entry %h, expected %h at index %0d",
                                                  cells.cell_entry, w.cell_entry,
                                                  w.cell_index));
                    if (cells.last_write !== w.last_write)
                        report_mismatch($sformatf("last_write %b, expected %b at index %0d",
                                                  cells.last_write, w.last_write,
                                                  w.cell_index));
                end
            end
            pending_total = expected_writes.size();
        end
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the text-mode terminal writer testbench: clock, reset, character stimulus,
// output back-pressure and the verdict. Depends on tmtw_pkg, tmtw_if and cell_write_checker.
module testbench;
    import tmtw_pkg::*;

    localparam int COLUMNS     = DEF_COLUMNS;
    localparam int ROWS        = DEF_ROWS;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 20;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tmtw_char_if chars();
    tmtw_cell_if cells();

    int fail_count;
    int pending;
    int chars_seen;
    int cells_seen;

    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;

    text_mode_terminal_writer_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .cells (cells)
    );

    cell_write_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) cell_write_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .cells      (cells),
        .fail_count (fail_count),
        .pending    (pending),
        .chars_seen (chars_seen),
        .cells_seen (cells_seen)
    );

    always #10 clk = ~clk;

    // Bound the run
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offer one character, idling first at random, and hold until accepted
    task automatic send_char(input logic [CHAR_W-1:0] code);
        while (!no_idle && $urandom_range(0, 99) < 20)
        begin
            chars.valid <= 1'b0;
            @(posedge clk);
        end
        chars.valid     <= 1'b1;
        chars.char_code <= code;
        do
            @(posedge clk);
        while (!chars.ready);
    endtask

    // Stop offering and wait until every predicted cell write has arrived
    task automatic drain_writes();
        chars.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Random character: mostly text with control codes mixed in; the scroll mix
    // drops form feed and adds newlines so the cursor reaches the bottom row
    function automatic logic [CHAR_W-1:0] pick_char(input bit scroll_mix);
        int                roll;
        logic [CHAR_W-1:0] c;
        roll = $urandom_range(0, 99);
        if (scroll_mix && roll < 12)
            c = CH_LF;
        else if (roll < 50)
        begin
            do
                c = 8'($urandom_range(1, 255));
            while (c inside {CH_BEL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR});
        end
        else if (roll < 60)
            c = CH_TAB;
        else if (roll < 68)
            c = CH_LF;
        else if (roll < 73)
            c = CH_BS;
        else if (roll < 77)
            c = CH_CR;
        else if (roll < 81)
            c = CH_VT;
        else if (roll < 84)
            c = scroll_mix ? CH_LF : CH_FF;
        else if (roll < 87)
            c = CH_BEL;
        else if (roll < 90)
            c = CH_NUL;
        else
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Drive the output ready: random stalls, quiet stretches and one long hold-off
    initial
    begin
        cells.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                cells.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            cells.ready <= no_idle || ($urandom_range(0, 99) >= 20);
        end
    end

    // Reset, stimulus and verdict
    initial
    begin
        logic [CHAR_W-1:0] directed[$];
        int                i;

        chars.valid     = 1'b0;
        chars.char_code = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: home backspace, field extremes, wraps and every control code
        directed = '{CH_BS, CH_NUL, 8'h41, 8'hFF, 8'h80, 8'h7F, CH_SPACE, CH_TAB,
                     CH_BS, CH_CR, CH_LF, CH_BS, CH_VT, 8'h5A, CH_TAB, CH_BEL,
                     8'h01, 8'h0E, 8'h06, CH_VT, CH_FF, CH_TAB, 8'hAA, 8'h55};
        foreach (directed[k])
            send_char(directed[k]);

        // General random mix with idling on both sides
        for (i = 0; i < 90; i++)
            send_char(pick_char(1'b0));

        // Hold the output off while tabs keep coming, then let everything drain
        hold_request = 1'b1;
        for (i = 0; i < 16; i++)
            send_char(CH_TAB);
        drain_writes();

        // Scroll-heavy mix with no idling at all
        no_idle = 1'b1;
        for (i = 0; i < 90; i++)
            send_char(pick_char(1'b1));
        no_idle = 1'b0;

        drain_writes();
        repeat (SETTLE) @(posedge clk);

        $display("Summary: %0d characters accepted, %0d cell writes checked,", chars_seen,
                 cells_seen);
        $display("  covering every control code, cursor wrap and a long output stall.");
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/tmtw_pkg.sv
rtl/core/tmtw_if.sv
rtl/core/tmtw_front.sv
rtl/core/tmtw_queue.sv
rtl/core/tmtw_back.sv
rtl/core/text_mode_terminal_writer_unit.sv
tb/cell_write_checker.sv
tb/testbench.sv
